/* sv/lpd_pkg.sv */
// Shared constants, types and helpers for the Legendre polynomial and derivative block.
package lpd_pkg;

   // Parameter defaults
   localparam int MAX_ORDER_DEF = 64;
   localparam int FRAC_BITS_DEF = 30;

   // Fixed field widths
   localparam int X_W     = 32;
   localparam int ORDER_W = 7;
   localparam int P_W     = 32;
   localparam int D_W     = 48;

   // Second multiplier operand width and divider bits retired per cycle
   localparam int MUL_B_W  = 32;
   localparam int DIV_BITS = 4;

   // Divider request from the sequencer
   typedef struct packed {
      logic start;   // load operands and begin
      logic full;    // long divide with fraction bits appended
   } div_ctl_type;

   // Round a bit count up to whole divider cycles
   function automatic int round_up(input int bits);
      return ((bits + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   endfunction

endpackage

/* sv/lpd_mul.sv */
// Shared signed multiplier with a registered product.
module lpd_mul #(
   parameter int A_W = 35,
   parameter int B_W = 32
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      mul_a,
   input  logic signed [B_W-1:0]      mul_b,
   output logic signed [A_W+B_W-1:0]  prod
);

   logic signed [A_W+B_W-1:0] prod_ff;

   // one product per cycle, ready the cycle after the operands
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

/* sv/lpd_div.sv */
// Iterative unsigned restoring divider, lpd_pkg::DIV_BITS quotient bits per cycle.
module lpd_div #(
   parameter int MAG_W     = 67,
   parameter int DEN_W     = 34,
   parameter int FRAC_BITS = 30,
   parameter int SHORT_LEN = 68,
   parameter int LONG_LEN  = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lpd_pkg::div_ctl_type      ctl,
   input  logic [MAG_W-1:0]          mag,
   input  logic [DEN_W-1:0]          den,
   output logic                      done,
   output logic [LONG_LEN-1:0]       quot
);

   localparam int STEP    = lpd_pkg::DIV_BITS;
   localparam int N_SHORT = SHORT_LEN / STEP;
   localparam int N_LONG  = LONG_LEN / STEP;
   localparam int CNT_W   = $clog2(N_LONG + 1);

   logic [LONG_LEN-1:0] q_ff;
   logic [DEN_W-1:0]    r_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                run_ff;
   logic                done_ff;

   logic [LONG_LEN-1:0] q_step;
   logic [DEN_W-1:0]    r_step;
   logic [LONG_LEN-1:0] q_load;
   logic                done_in;

   // dividend sits at the top of q; quotient bits shift in at the bottom
   // short: bare magnitude, long: magnitude with FRAC_BITS zeros appended
   assign q_load = ctl.full ? (LONG_LEN'(mag) << FRAC_BITS)
                            : (LONG_LEN'(mag) << (LONG_LEN - SHORT_LEN));

   // STEP restoring steps on the narrow remainder
   always_comb begin : div_step
      logic [DEN_W:0] trial;
      q_step = q_ff;
      r_step = r_ff;
      trial  = '0;
      for (int k = 0; k < STEP; k++) begin
         trial  = {r_step, q_step[LONG_LEN-1]};
         q_step = {q_step[LONG_LEN-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            r_step    = DEN_W'(trial - {1'b0, den_ff});
            q_step[0] = 1'b1;
         end else begin
            r_step = trial[DEN_W-1:0];
         end
      end
   end

   // last running cycle raises done
   assign done_in = run_ff && !ctl.start && (cnt_ff == CNT_W'(1));

   // control: cycle count and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= done_in;
         if (ctl.start) begin
            run_ff <= 1'b1;
            cnt_ff <= ctl.full ? CNT_W'(N_LONG) : CNT_W'(N_SHORT);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         q_ff   <= q_load;
         r_ff   <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         q_ff <= q_step;
         r_ff <= r_step;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* sv/legendre_poly_and_derivative.sv */
// Legendre polynomial P_n(x) and its derivative by the three-term recurrence, fixed point.
//
//   channel  ports                                  handshake
//   request  req_x_value, req_order                 start high while busy low
//   result   rsp_p_value, rsp_d_value, rsp_div_zero rsp_valid, one cycle, no backpressure
//
// Order 0 answers in the cycle after it is accepted. Otherwise each recurrence
// step runs S_RT, S_RC, S_RP, S_RN and S_RS and waits in S_RW on the divider,
// and the derivative tail runs S_FX, S_FT, S_FZ, S_FM and S_FA and waits in S_FW;
// when x*x is one the tail stops at S_FZ. The divider, retiring 4 quotient bits
// a cycle, sets the length of each wait.
// Reset is synchronous and leaves the block idle; busy stays high until the word
// is delivered, and a new word may be started in the cycle rsp_valid is high.
module legendre_poly_and_derivative #(
   parameter int MAX_ORDER = lpd_pkg::MAX_ORDER_DEF,
   parameter int FRAC_BITS = lpd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [lpd_pkg::X_W-1:0]      req_x_value,
   input  logic [lpd_pkg::ORDER_W-1:0]         req_order,
   output logic                                rsp_valid,
   output logic signed [lpd_pkg::P_W-1:0]      rsp_p_value,
   output logic signed [lpd_pkg::D_W-1:0]      rsp_d_value,
   output logic                                rsp_div_zero
);

   localparam int P_W   = lpd_pkg::P_W;
   localparam int D_W   = lpd_pkg::D_W;
   localparam int X_W   = lpd_pkg::X_W;
   localparam int MB_W  = lpd_pkg::MUL_B_W;
   localparam int ORD_W = $clog2(MAX_ORDER + 1);

   // x*P truncated by FRAC_BITS
   localparam int TW    = 2 * X_W - FRAC_BITS;
   // t - P_{n-1}, also the first multiplier operand width
   localparam int MA_W  = ((TW > P_W) ? TW : P_W) + 1;
   localparam int PR_W  = MA_W + MB_W;
   // |x*x - 1| magnitude width
   localparam int DEN_W = (FRAC_BITS + 1 > 2 * X_W - 1 - FRAC_BITS) ?
                          FRAC_BITS + 1 : 2 * X_W - 1 - FRAC_BITS;
   localparam int SHORT_LEN = lpd_pkg::round_up(PR_W);
   localparam int LONG_LEN  = lpd_pkg::round_up(PR_W + FRAC_BITS);

   localparam logic [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
   localparam logic [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};
   localparam logic [D_W-1:0] D_MAX = {1'b0, {(D_W-1){1'b1}}};
   localparam logic [D_W-1:0] D_MIN = {1'b1, {(D_W-1){1'b0}}};
   localparam logic [LONG_LEN-1:0] Q_PMAX = LONG_LEN'(P_MAX);
   localparam logic [LONG_LEN-1:0] Q_PNEG = LONG_LEN'(P_MIN);
   localparam logic [LONG_LEN-1:0] Q_DCAP = LONG_LEN'(D_MIN);
   localparam logic signed [PR_W-1:0] ONE_PR = PR_W'(1) << FRAC_BITS;
   localparam logic [P_W-1:0] ONE_SAT = (FRAC_BITS >= P_W - 1) ? P_MAX : P_W'(ONE_PR);
   localparam logic [8:0] MAX_ORD9 = 9'(MAX_ORDER);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RT,    // x * P_i
      S_RC,    // (2i+1) * t
      S_RP,    // i * P_{i-1}
      S_RN,    // numerator
      S_RS,    // start divide by i+1
      S_RW,    // wait, saturate, advance
      S_FX,    // x * x
      S_FT,    // denominator, x * P_n
      S_FZ,    // zero check, t - P_{n-1}
      S_FM,    // n * (t - P_{n-1})
      S_FA,    // start fraction divide
      S_FW     // wait, saturate, deliver
   } state_type;

   state_type                  state_ff;
   logic signed [X_W-1:0]      x_ff;
   logic [ORD_W-1:0]           n_ff;
   logic [ORD_W-1:0]           i_ff;
   logic signed [P_W-1:0]      pn_ff;
   logic signed [P_W-1:0]      pm_ff;
   logic signed [PR_W-1:0]     acc_ff;
   logic signed [PR_W-1:0]     num_ff;
   logic signed [DEN_W:0]      den_ff;
   logic signed [MA_W-1:0]     diff_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff;
   logic signed [P_W-1:0]      rsp_p_ff;
   logic signed [D_W-1:0]      rsp_d_ff;
   logic                       rsp_flag_ff;

   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [PR_W-1:0]     prod;
   logic signed [TW-1:0]       t_w;
   logic signed [PR_W-1:0]     den_w;
   logic [DEN_W-1:0]           den_mag;
   logic [ORD_W-1:0]           i_nx;
   logic [ORD_W:0]             coef;
   logic [8:0]                 n_clamp;
   logic [ORD_W-1:0]           n_start;
   lpd_pkg::div_ctl_type       div_ctl;
   logic [PR_W-1:0]            div_mag;
   logic [DEN_W-1:0]           div_den;
   logic                       div_done;
   logic [LONG_LEN-1:0]        div_quot;
   logic signed [P_W-1:0]      p_sat;
   logic signed [D_W-1:0]      d_sat;
   logic                       rsp_valid_in;

   // order clamp
   assign n_clamp = (9'(req_order) > MAX_ORD9) ? MAX_ORD9 : 9'(req_order);
   assign n_start = ORD_W'(n_clamp);

   // product taken apart
   assign t_w     = TW'(prod >>> FRAC_BITS);
   assign den_w   = (prod >>> FRAC_BITS) - ONE_PR;
   assign den_mag = den_ff[DEN_W] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
   assign i_nx    = i_ff + ORD_W'(1);
   assign coef    = {i_ff, 1'b1};

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_RT: begin
            mul_a = MA_W'(pn_ff);
            mul_b = MB_W'(x_ff);
         end
         S_RC: begin
            mul_a = MA_W'(t_w);
            mul_b = signed'(MB_W'(coef));
         end
         S_RP: begin
            mul_a = MA_W'(pm_ff);
            mul_b = signed'(MB_W'(i_ff));
         end
         S_FX: begin
            mul_a = MA_W'(x_ff);
            mul_b = MB_W'(x_ff);
         end
         S_FT: begin
            mul_a = MA_W'(pn_ff);
            mul_b = MB_W'(x_ff);
         end
         S_FM: begin
            mul_a = diff_ff;
            mul_b = signed'(MB_W'(n_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   lpd_mul #(
      .A_W (MA_W),
      .B_W (MB_W)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // divider request: recurrence divide by i+1, or fraction divide by |x*x-1|
   always_comb begin
      div_ctl.start = (state_ff == S_RS) || (state_ff == S_FA);
      div_ctl.full  = (state_ff == S_FA);
      if (state_ff == S_FA) begin
         div_mag = prod[PR_W-1] ? PR_W'(-prod) : PR_W'(prod);
         div_den = den_mag;
      end else begin
         div_mag = num_ff[PR_W-1] ? PR_W'(-num_ff) : PR_W'(num_ff);
         div_den = DEN_W'(i_nx);
      end
   end

   lpd_div #(
      .MAG_W     (PR_W),
      .DEN_W     (DEN_W),
      .FRAC_BITS (FRAC_BITS),
      .SHORT_LEN (SHORT_LEN),
      .LONG_LEN  (LONG_LEN)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .mag   (div_mag),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // signed, saturated quotients
   always_comb begin
      if (neg_ff) begin
         p_sat = (div_quot > Q_PNEG) ? P_MIN : -div_quot[P_W-1:0];
         d_sat = (div_quot >= Q_DCAP) ? D_MIN : -div_quot[D_W-1:0];
      end else begin
         p_sat = (div_quot > Q_PMAX) ? P_MAX : div_quot[P_W-1:0];
         d_sat = (div_quot >= Q_DCAP) ? D_MAX : div_quot[D_W-1:0];
      end
   end

   // a result word leaves at the end of each finishing state
   assign rsp_valid_in = ((state_ff == S_IDLE) && start && (n_start == '0)) ||
                         ((state_ff == S_FZ) && (den_ff == '0)) ||
                         ((state_ff == S_FW) && div_done);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  x_ff  <= req_x_value;
                  n_ff  <= n_start;
                  pn_ff <= req_x_value;
                  pm_ff <= ONE_SAT;
                  i_ff  <= ORD_W'(1);
                  if (n_start == '0) begin
                     rsp_p_ff     <= ONE_SAT;
                     rsp_d_ff     <= '0;
                     rsp_flag_ff  <= 1'b0;
                  end else if (n_start == ORD_W'(1)) begin
                     state_ff <= S_FX;
                  end else begin
                     state_ff <= S_RT;
                  end
               end
            end
            S_RT: state_ff <= S_RC;
            S_RC: state_ff <= S_RP;
            S_RP: begin
               acc_ff   <= prod;
               state_ff <= S_RN;
            end
            S_RN: begin
               num_ff   <= acc_ff - prod;
               state_ff <= S_RS;
            end
            S_RS: begin
               neg_ff   <= num_ff[PR_W-1];
               state_ff <= S_RW;
            end
            S_RW: begin
               if (div_done) begin
                  pm_ff <= pn_ff;
                  pn_ff <= p_sat;
                  i_ff  <= i_nx;
                  state_ff <= (i_nx < n_ff) ? S_RT : S_FX;
               end
            end
            S_FX: state_ff <= S_FT;
            S_FT: begin
               den_ff   <= (DEN_W+1)'(den_w);
               state_ff <= S_FZ;
            end
            S_FZ: begin
               if (den_ff == '0) begin
                  rsp_p_ff     <= pn_ff;
                  rsp_d_ff     <= '0;
                  rsp_flag_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  diff_ff  <= MA_W'(t_w) - MA_W'(pm_ff);
                  state_ff <= S_FM;
               end
            end
            S_FM: state_ff <= S_FA;
            S_FA: begin
               neg_ff   <= prod[PR_W-1] ^ den_ff[DEN_W];
               state_ff <= S_FW;
            end
            S_FW: begin
               if (div_done) begin
                  rsp_p_ff     <= pn_ff;
                  rsp_d_ff     <= d_sat;
                  rsp_flag_ff  <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_p_value  = rsp_p_ff;
   assign rsp_d_value  = rsp_d_ff;
   assign rsp_div_zero = rsp_flag_ff;

   // a result word only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while sequencer busy");

   // an accepted word either answers at once or keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word dropped");

   // zero denominator forces a zero derivative
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_d_value == '0))
      else $error("derivative not cleared on zero denominator");

   // divider finishes only while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_RW || state_ff == S_FW))
      else $error("divider done outside a wait state");

endmodule
